// File: hw/rtl/dtts_pkg.sv
// ----------------------------------------------------------------------------
// dtts_pkg: shared types and constants for the date/time to seconds unit
// Holds the controller states, the command and status groups between the
// controller and the datapath, calendar constants and the month table.
// ----------------------------------------------------------------------------
package dtts_pkg;

  // Field widths
  localparam int CfgW    = 12;
  localparam int YearW   = 13;   // year offset plus year base
  localparam int TsW     = 32;
  localparam int SDataW  = 40;   // 34 bits of fields, padded to whole bytes
  localparam int CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_YEAR_BASE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EPOCH_YEAR = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_END_YEAR   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CfgW-1:0] YEAR_BASE_RST  = 12'd2000;
  localparam logic [CfgW-1:0] EPOCH_YEAR_RST = 12'd1970;
  localparam logic [CfgW-1:0] END_YEAR_RST   = 12'd2099;

  // Seconds per unit
  localparam logic [TsW-1:0] SECS_DAY    = 32'd86400;
  localparam logic [TsW-1:0] SECS_HOUR   = 32'd3600;
  localparam logic [TsW-1:0] SECS_MINUTE = 32'd60;
  localparam logic [TsW-1:0] SECS_YEAR   = 32'd31536000;
  localparam logic [TsW-1:0] SECS_LEAP   = 32'd31622400;

  // Reciprocal of 25 for the epoch year remainder: q = (y * RECIP25) >> 17
  localparam logic [12:0] RECIP25 = 13'd5243;
  localparam int          RECIP_SHIFT = 17;
  localparam logic [4:0]  MOD25_LAST = 5'd24;
  localparam logic [4:0]  MOD25_BASE = 5'd25;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_YEARS,
    ST_SUM,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // latch an item, start the year counter at the epoch
    logic init;       // set up the mod-25 counter, clear the total
    logic year_step;  // add one whole year, advance the counter
    logic mult;       // form the day, hour and minute products
    logic sum;        // fold products and seconds into the total
    logic emit;       // load the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic valid;      // year, month and day pass the checks
    logic year_done;  // running year has reached the item's year
    logic out_busy;   // output register holds an item not yet taken
  } sts_t;

  // Days before the first of each month in a common year
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/dtts_ctrl.sv
// ----------------------------------------------------------------------------
// dtts_ctrl: sequencer for the date/time to seconds unit
// Walks one item through check, year walk, products and sum if valid, output.
// ----------------------------------------------------------------------------
module dtts_ctrl
  import dtts_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.init   = 1'b1;
        state_next = sts.valid ? ST_YEARS : ST_EMIT;
      end
      ST_YEARS: begin
        if (sts.year_done) begin
          cmd.mult   = 1'b1;
          state_next = ST_SUM;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold until the output register is free
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/dtts_datapath.sv
// ----------------------------------------------------------------------------
// dtts_datapath: registers and arithmetic of the date/time to seconds unit
// Configuration registers, year walk with leap tracking, products, total
// and the output register.
// ----------------------------------------------------------------------------
module dtts_datapath
  import dtts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  input  logic [7:0]         year_offset,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  input  logic [4:0]         hour,
  input  logic [5:0]         minute,
  input  logic [5:0]         second,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TsW-1:0]     timestamp
);

  logic [CfgW-1:0]  year_base;
  logic [CfgW-1:0]  epoch_year;
  logic [CfgW-1:0]  end_year;

  logic [YearW-1:0] year;
  logic [3:0]       mon;
  logic [4:0]       dy;
  logic [4:0]       hr;
  logic [5:0]       mn;
  logic [5:0]       sec;

  logic [YearW-1:0] yr;
  logic [7:0]       quot25;
  logic [4:0]       mod25;
  logic [TsW-1:0]   total;
  logic [TsW-1:0]   prod_d;
  logic [TsW-1:0]   prod_h;
  logic [TsW-1:0]   prod_m;

  logic [24:0]      recip_prod;
  logic [YearW-1:0] rem25;
  logic             leap;
  logic [8:0]       days;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      year_base  <= YEAR_BASE_RST;
      epoch_year <= EPOCH_YEAR_RST;
      end_year   <= END_YEAR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_YEAR_BASE:  year_base  <= cfg_data;
        CFG_EPOCH_YEAR: epoch_year <= cfg_data;
        CFG_END_YEAR:   end_year   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Quotient of the epoch year by 25, and the remainder from it
  assign recip_prod = 25'(epoch_year) * 25'(RECIP25);
  assign rem25      = yr - 13'(quot25) * 13'(MOD25_BASE);

  // Leap rule from the low bits of the year and its remainder mod 25
  assign leap = (yr[1:0] == 2'd0) && ((mod25 != 5'd0) || (yr[3:0] == 4'd0));

  // Days before the given day within the year
  assign days = days_before(mon) + 9'(dy) - 9'd1
              + ((leap && (mon > MONTH_FEB)) ? 9'd1 : 9'd0);

  // Status
  assign sts.valid = ({1'b0, epoch_year} <= year) && (year <= {1'b0, end_year})
                   && (mon != 4'd0) && (mon <= MONTH_DEC) && (dy != 5'd0);
  assign sts.year_done = (yr == year);
  assign sts.out_busy  = out_valid && !out_ready;

  // Item fields and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year   <= YearW'(year_offset) + YearW'(year_base);
      mon    <= month;
      dy     <= day;
      hr     <= hour;
      mn     <= minute;
      sec    <= second;
      yr     <= YearW'(epoch_year);
      quot25 <= recip_prod[24:RECIP_SHIFT];
    end
    if (cmd.init) begin
      mod25 <= rem25[4:0];
      total <= '0;
    end
    if (cmd.year_step) begin
      total <= total + (leap ? SECS_LEAP : SECS_YEAR);
      yr    <= yr + YearW'(1);
      mod25 <= (mod25 == MOD25_LAST) ? 5'd0 : mod25 + 5'd1;
    end
    if (cmd.mult) begin
      prod_d <= TsW'(days) * SECS_DAY;
      prod_h <= TsW'(hr) * SECS_HOUR;
      prod_m <= TsW'(mn) * SECS_MINUTE;
    end
    if (cmd.sum) begin
      total <= total + prod_d + prod_h + prod_m + TsW'(sec);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      timestamp <= total;
    end
  end

endmodule

// File: hw/rtl/date_time_to_seconds_unit.sv
// ----------------------------------------------------------------------------
// date_time_to_seconds_unit: calendar date and time to epoch seconds
// An item on the slave stream carries year offset, month, day, hour, minute
// and second; the master stream returns the seconds since January 1 of the
// configured epoch year, or zero when the year, month or day is invalid.
// The configuration port writes year base, epoch year and end year (index
// 0, 1, 2); a write to index 3 is ignored. Write only while idle.
// An item is invalid when its year lies outside the epoch and end years, its
// month is not 1 to 12 or its day is zero. For a valid item the year walk
// adds one whole year at a time from the epoch year up to the item's year,
// then come the products, the sum and the output register; an invalid item
// goes from the check straight to the output register.
// The result sits in an output register, so a stalled m_tready does not
// stop the unit taking a new item; the unit only waits when a second result
// is ready and the first has not been taken.
// Reset (rst, synchronous) empties the output register, returns the
// sequencer to idle and restores year base 2000, epoch 1970, end 2099.
// ----------------------------------------------------------------------------
module date_time_to_seconds_unit
  import dtts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // year_offset[7:0], month[11:8], day[16:12], hour[21:17],
  // minute[27:22], second[33:28], zero[39:34]
  input  logic [SDataW-1:0]  s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  // timestamp[31:0]
  output logic [TsW-1:0]     m_tdata,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  cmd_t cmd;
  sts_t sts;

  dtts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dtts_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .year_offset (s_tdata[7:0]),
    .month       (s_tdata[11:8]),
    .day         (s_tdata[16:12]),
    .hour        (s_tdata[21:17]),
    .minute      (s_tdata[27:22]),
    .second      (s_tdata[33:28]),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .timestamp   (m_tdata)
  );

endmodule

// File: test/tb_date_time_to_seconds_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_date_time_to_seconds_unit: self-checking bench for the date/time unit
// Drives date and time items into the slave stream under several register
// settings. A scoreboard works out each expected timestamp on its own and
// compares it with every item taken from the master stream. Both streams
// idle at random, and the sink holds off now and then to stall the unit.
// ----------------------------------------------------------------------------
module tb_date_time_to_seconds_unit;
  import dtts_pkg::*;

  // Write to this index must leave every register as it was
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int RANDOM_PHASES   = 8;

  // --------------------------------------------------------------------------
  // Scoreboard: register copy, timestamp prediction, expected results
  // --------------------------------------------------------------------------
  class stamp_scoreboard;
    int unsigned year_base;
    int unsigned epoch_year;
    int unsigned end_year;
    int unsigned month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    logic [TsW-1:0] expected_stamps[$];
    int errors;

    function new();
      year_base  = 32'(YEAR_BASE_RST);
      epoch_year = 32'(EPOCH_YEAR_RST);
      end_year   = 32'(END_YEAR_RST);
      errors     = 0;
    endfunction

    function void set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
      case (idx)
        CFG_YEAR_BASE:  year_base  = 32'(val);
        CFG_EPOCH_YEAR: epoch_year = 32'(val);
        CFG_END_YEAR:   end_year   = 32'(val);
        default: ;
      endcase
    endfunction

    function bit leap_year(input int unsigned y);
      return ((y % 400) == 0) || (((y % 100) != 0) && ((y % 4) == 0));
    endfunction

    function logic [TsW-1:0] seconds_since_epoch(input logic [SDataW-1:0] d);
      logic [7:0]     yoff;
      logic [3:0]     mon;
      logic [4:0]     day;
      logic [4:0]     hr;
      logic [5:0]     mn;
      logic [5:0]     sc;
      int unsigned    full_year;
      int unsigned    y;
      int unsigned    m;
      logic [TsW-1:0] total;
      yoff = d[7:0];
      mon  = d[11:8];
      day  = d[16:12];
      hr   = d[21:17];
      mn   = d[27:22];
      sc   = d[33:28];
      full_year = 32'(yoff) + year_base;
      // Zero for a year outside the window, a month of 0 or above 12, or a day of 0
      if (full_year < epoch_year || full_year > end_year) return '0;
      if (mon == 4'd0 || mon > MONTH_DEC || day == 5'd0) return '0;
      total = '0;
      // Whole years from the epoch up to the given year
      for (y = epoch_year; y < full_year; y++) begin
        total += leap_year(y) ? SECS_LEAP : SECS_YEAR;
      end
      // Whole months before the given one, leap day in February
      for (m = 1; m < 32'(mon); m++) begin
        total += month_len[m-1] * SECS_DAY;
        if (m == 32'(MONTH_FEB) && leap_year(full_year)) total += SECS_DAY;
      end
      total += (TsW'(day) - TsW'(1)) * SECS_DAY;
      total += TsW'(hr) * SECS_HOUR;
      total += TsW'(mn) * SECS_MINUTE;
      total += TsW'(sc);
      return total;
    endfunction

    function void note_item(input logic [SDataW-1:0] d);
      expected_stamps.push_back(seconds_since_epoch(d));
    endfunction

    function void check_result(input logic [TsW-1:0] got);
      logic [TsW-1:0] want;
      if (expected_stamps.size() == 0) begin
        $error("timestamp: no item outstanding, got %0d", got);
        errors++;
        return;
      end
      want = expected_stamps.pop_front();
      if (got !== want) begin
        $error("timestamp: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction

    function void close_out();
      if (expected_stamps.size() != 0) begin
        $error("timestamp: %0d results never arrived", expected_stamps.size());
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT signals and instance
  // --------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  // year_offset[7:0], month[11:8], day[16:12], hour[21:17],
  // minute[27:22], second[33:28], zero[39:34]
  logic [SDataW-1:0]  s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // timestamp[31:0]
  logic [TsW-1:0]     m_tdata;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;

  stamp_scoreboard sb = new();
  int unsigned cur_base  = 32'(YEAR_BASE_RST);
  int unsigned cur_epoch = 32'(EPOCH_YEAR_RST);
  int unsigned cur_end   = 32'(END_YEAR_RST);
  int results_taken = 0;
  int send_calm = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  date_time_to_seconds_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  // Mostly short gaps, a few long ones, and calm stretches with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SDataW-1:0] pack_fields(input logic [7:0] yoff,
      input logic [3:0] mon, input logic [4:0] day, input logic [4:0] hr,
      input logic [5:0] mn, input logic [5:0] sc);
    return {{(SDataW-34){1'b0}}, sc, mn, hr, day, mon, yoff};
  endfunction

  // Mostly valid dates in the current window, the rest raw noise or stray fields
  function automatic logic [SDataW-1:0] random_item();
    int unsigned lo;
    int unsigned hi;
    logic [7:0]  yoff;
    if ($urandom_range(0, 9) < 2) begin
      return pack_fields(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                         5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                         6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    end
    lo = (cur_epoch > cur_base) ? cur_epoch : cur_base;
    hi = (cur_end < cur_base + 255) ? cur_end : cur_base + 255;
    if (lo <= hi && $urandom_range(0, 9) != 0) begin
      yoff = 8'($urandom_range(lo, hi) - cur_base);
    end else begin
      yoff = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 3) == 0) begin
      return pack_fields(yoff, 4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)),
                         5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                         6'($urandom_range(0, 63)));
    end
    return pack_fields(yoff, 4'($urandom_range(1, 12)), 5'($urandom_range(1, 28)),
                       5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                       6'($urandom_range(0, 59)));
  endfunction

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(input logic [SDataW-1:0] d);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_item(d);
  endtask

  task automatic send_date(input logic [7:0] yoff, input logic [3:0] mon,
      input logic [4:0] day, input logic [4:0] hr, input logic [5:0] mn,
      input logic [5:0] sc);
    send_item(pack_fields(yoff, mon, day, hr, mn, sc));
  endtask

  // Drop valid and wait until every result has been taken
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_stamps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Write all three registers, then poke the unused index
  task automatic apply_config(input int unsigned base, input int unsigned epoch,
      input int unsigned last_year);
    write_reg(CFG_YEAR_BASE, CfgW'(base));
    write_reg(CFG_EPOCH_YEAR, CfgW'(epoch));
    write_reg(CFG_END_YEAR, CfgW'(last_year));
    write_reg(CFG_UNUSED, CfgW'($urandom_range(0, 4095)));
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_base  = base;
    cur_epoch = epoch;
    cur_end   = last_year;
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random stalls, two long hold-offs to back the unit up
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    int calm;
    calm = 0;
    while (rst) @(posedge clk);
    forever begin
      if (results_taken == 150 || results_taken == 550) begin
        gap = HOLD_OFF_CYCLES;
      end else begin
        gap = pick_gap(calm);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      results_taken++;
      sb.check_result(m_tdata);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned epoch;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: base 2000, epoch 1970, end 2099
    send_date(8'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(8'd0, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30);
    send_date(8'd0, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(8'd96, 4'd3, 5'd1, 5'd0, 6'd0, 6'd1);
    send_date(8'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    send_date(8'd100, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(8'd255, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
    send_date(8'd20, 4'd0, 5'd10, 5'd1, 6'd1, 6'd1);
    send_date(8'd20, 4'd13, 5'd10, 5'd1, 6'd1, 6'd1);
    send_date(8'd20, 4'd15, 5'd10, 5'd1, 6'd1, 6'd1);
    send_date(8'd20, 4'd6, 5'd0, 5'd1, 6'd1, 6'd1);
    send_date(8'd50, 4'd7, 5'd31, 5'd31, 6'd63, 6'd63);
    drain();

    // Widest window: century rule and the longest year walk
    apply_config(1900, 1900, 2200);
    send_date(8'd0, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(8'd100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(8'd200, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(8'd255, 4'd12, 5'd31, 5'd31, 6'd63, 6'd63);
    drain();

    // Year just below and at the epoch
    apply_config(1900, 2000, 2100);
    send_date(8'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    send_date(8'd100, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    drain();

    // Epoch above end year: everything is zero
    apply_config(2000, 2100, 1900);
    send_date(8'd100, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_date(8'd0, 4'd6, 5'd15, 5'd10, 6'd10, 6'd10);
    drain();

    // Random items over fixed extremes, then random windows
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: apply_config(32'(YEAR_BASE_RST), 32'(EPOCH_YEAR_RST), 32'(END_YEAR_RST));
        1: apply_config(1900, 1900, 2200);
        2: apply_config(2100, 2100, 2100);
        3: apply_config(1900, 2100, 2200);
        default: begin
          epoch = $urandom_range(1900, 2100);
          if ($urandom_range(0, 7) == 0) begin
            apply_config($urandom_range(1900, 2100), epoch, $urandom_range(1900, 2200));
          end else begin
            apply_config($urandom_range(1900, 2100), epoch, $urandom_range(epoch, 2200));
          end
        end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_item(random_item());
      end
      drain();
    end

    repeat (20) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("** date_time_to_seconds_unit: PASSED **");
    end else begin
      $display("** date_time_to_seconds_unit: FAILED **");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin : watchdog
    #40_000_000;
    $display("** date_time_to_seconds_unit: FAILED **");
    $finish;
  end

endmodule
